@@ hdl/assert_macros.svh @@
// Assertion helpers for the filter blocks; they expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GMF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("property violated");

// Condition must never be seen outside reset.
`define GMF_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ hdl/gmf_pkg.sv @@
package gmf_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned MASK_W     = 9;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // queue between classifier and datapath, and result queue (powers of two)
  localparam int unsigned CLS_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_MASK   = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_e;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } mode_e;

  localparam logic [MASK_W-1:0] MASK_RST = 9'd186;
  localparam logic [DIM_W-1:0]  DIM_RST  = 11'd1024;

  typedef struct packed {
    mode_e              mode;
    logic [MASK_W-1:0]  mask;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  // one classified pixel
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    logic               interior;
    logic               border;
  } cls_t;

  // results caused by one pixel, interior first
  typedef struct packed {
    logic               has_int;
    logic [PIX_W-1:0]   int_val;
    logic [COORD_W-1:0] int_row;
    logic [COORD_W-1:0] int_col;
    logic               has_bor;
    logic [PIX_W-1:0]   bor_val;
    logic [COORD_W-1:0] bor_row;
    logic [COORD_W-1:0] bor_col;
  } res_t;

endpackage

@@ hdl/gmf_fifo.sv @@
module gmf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d;
  logic [AW-1:0]    rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;

  assign data_o  = store_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(DEPTH));

  always_comb begin
    wr_d  = push_i ? wr_q + AW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + NW'(push_i) - NW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hdl/gmf_front.sv @@
module gmf_front import gmf_pkg::*; #(
  parameter int unsigned KERNEL_SIZE = 3,
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cfg_t                             cfg_i,
  input  logic                             in_valid_i,
  input  logic [PIX_W-1:0]                 pixel_i,
  input  logic                             q_full_i,
  output logic                             in_ready_o,
  output logic                             push_o,
  output cls_t                             cls_o,
  output logic [$clog2(MAX_WIDTH)-1:0]     addr_o,
  output logic [$clog2(KERNEL_SIZE-1)-1:0] slot_o
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EW   = ((WW > HW) ? WW : HW) + 2;
  localparam int unsigned ROWS = KERNEL_SIZE - 1;
  localparam int unsigned PW   = $clog2(ROWS);
  localparam int unsigned HALF = KERNEL_SIZE / 2;
  localparam int unsigned OFF  = KERNEL_SIZE - 1 - HALF;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [PW-1:0] slot_q, slot_d;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [EW-1:0] r_e, c_e, w_e, h_e;
  logic          accept, interior, border, row_end, frame_end;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // saturate frame size to the supported range
  always_comb begin
    if (cfg_i.width < KERNEL_SIZE) begin
      w = WW'(KERNEL_SIZE);
    end else if (cfg_i.width > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg_i.width);
    end
    if (cfg_i.height < KERNEL_SIZE) begin
      h = HW'(KERNEL_SIZE);
    end else if (cfg_i.height > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(cfg_i.height);
    end
  end

  always_comb begin
    r_e = EW'(row_q);
    c_e = EW'(col_q);
    w_e = EW'(w);
    h_e = EW'(h);
    interior = (r_e >= EW'(KERNEL_SIZE - 1)) && (c_e >= EW'(KERNEL_SIZE - 1)) &&
               (r_e + EW'(2 * HALF) <= h_e + EW'(KERNEL_SIZE - 2)) &&
               (c_e + EW'(2 * HALF) <= w_e + EW'(KERNEL_SIZE - 2));
    border   = (r_e < EW'(HALF)) || (r_e + EW'(HALF) >= h_e) ||
               (c_e < EW'(HALF)) || (c_e + EW'(HALF) >= w_e);
    row_end   = (c_e + EW'(1) >= w_e);
    frame_end = (r_e + EW'(1) >= h_e);
  end

  always_comb begin
    cls_o.pixel    = pixel_i;
    cls_o.row      = COORD_W'(row_q);
    cls_o.col      = COORD_W'(col_q);
    cls_o.y        = COORD_W'(row_q - RW'(OFF));
    cls_o.x        = COORD_W'(col_q - CW'(OFF));
    cls_o.interior = interior;
    cls_o.border   = border;
    addr_o         = col_q;
    slot_o         = slot_q;
  end

  // raster position; the line store slot of the current row rotates with it
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        if (frame_end) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_q + RW'(1);
          slot_d = (slot_q == PW'(ROWS - 1)) ? '0 : slot_q + PW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

endmodule

@@ hdl/gmf_back.sv @@
module gmf_back import gmf_pkg::*; #(
  parameter int unsigned KERNEL_SIZE = 3,
  parameter int unsigned MAX_WIDTH   = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cfg_t                             cfg_i,
  input  logic                             q_valid_i,
  input  cls_t                             q_cls_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]     q_addr_i,
  input  logic [$clog2(KERNEL_SIZE-1)-1:0] q_slot_i,
  output logic                             q_pop_o,
  input  logic                             retire_i,
  output logic                             res_push_o,
  output res_t                             res_o
);

  localparam int unsigned ROWS = KERNEL_SIZE - 1;
  localparam int unsigned PW   = $clog2(ROWS);
  localparam int unsigned CRW  = $clog2(RES_DEPTH + 1);
  localparam int unsigned GRP  = 3;
  localparam int unsigned NGRP = MASK_W / GRP;

  function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input mode_e m);
    if (m == MODE_DILATE) begin
      return (a > b) ? a : b;
    end
    return (a < b) ? a : b;
  endfunction

  logic [CRW-1:0]   credit_q, credit_d;
  logic             pop, inc;

  logic [PIX_W-1:0] line_q [ROWS][MAX_WIDTH];
  logic [PIX_W-1:0] rd_q [ROWS];

  logic             a_valid_q;
  cls_t             a_cls_q;
  logic [PW-1:0]    a_slot_q;

  logic [PW:0]      rot [ROWS];
  logic [PIX_W-1:0] col_pix [ROWS];
  logic [PIX_W-1:0] win_q [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0] win_d [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0] ident;
  logic [PIX_W-1:0] tap [MASK_W];
  logic [PIX_W-1:0] part_d [NGRP];

  logic             b_valid_q;
  cls_t             b_cls_q;
  logic [PIX_W-1:0] b_part_q [NGRP];
  logic [PIX_W-1:0] final_val;

  // issue only while the result queue has room for everything in flight
  assign pop      = q_valid_i && (credit_q < CRW'(RES_DEPTH));
  assign q_pop_o  = pop;
  assign inc      = pop && (q_cls_i.interior || q_cls_i.border);
  assign credit_d = credit_q + CRW'(inc) - CRW'(retire_i);

  // line store banks: read old data and write the new pixel in the same beat
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < ROWS; s++) begin
      if (pop && (q_slot_i == PW'(s))) begin
        line_q[s][q_addr_i] <= q_cls_i.pixel;
      end
      rd_q[s] <= line_q[s][q_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    a_cls_q  <= q_cls_i;
    a_slot_q <= q_slot_i;
  end

  // window row i takes the bank holding row r-(K-1)+i
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      rot[i] = (PW+1)'(a_slot_q) + (PW+1)'(i);
      if (rot[i] >= (PW+1)'(ROWS)) begin
        rot[i] = rot[i] - (PW+1)'(ROWS);
      end
      col_pix[i] = '0;
      for (int s = 0; s < ROWS; s++) begin
        if (rot[i] == (PW+1)'(s)) begin
          col_pix[i] = rd_q[s];
        end
      end
    end
  end

  // shift left and load the new column
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
        win_d[i][j] = win_q[i][j+1];
      end
    end
    for (int i = 0; i < ROWS; i++) begin
      win_d[i][KERNEL_SIZE-1] = col_pix[i];
    end
    win_d[KERNEL_SIZE-1][KERNEL_SIZE-1] = a_cls_q.pixel;
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      win_q <= win_d;
    end
  end

  // first level of the compare tree: masked taps in groups of three
  always_comb begin
    ident = (cfg_i.mode == MODE_DILATE) ? '0 : '1;
    for (int p = 0; p < MASK_W; p++) begin
      tap[p] = cfg_i.mask[p] ? win_d[p / KERNEL_SIZE][p % KERNEL_SIZE] : ident;
    end
    for (int g = 0; g < NGRP; g++) begin
      part_d[g] = pick(pick(tap[g*GRP], tap[g*GRP+1], cfg_i.mode), tap[g*GRP+2], cfg_i.mode);
    end
  end

  always_ff @(posedge clk_i) begin
    b_cls_q  <= a_cls_q;
    b_part_q <= part_d;
  end

  always_comb begin
    final_val = pick(pick(b_part_q[0], b_part_q[1], cfg_i.mode), b_part_q[2], cfg_i.mode);
    res_o.has_int = b_cls_q.interior;
    res_o.int_val = final_val;
    res_o.int_row = b_cls_q.y;
    res_o.int_col = b_cls_q.x;
    res_o.has_bor = b_cls_q.border;
    res_o.bor_val = b_cls_q.pixel;
    res_o.bor_row = b_cls_q.row;
    res_o.bor_col = b_cls_q.col;
    res_push_o    = b_valid_q && (b_cls_q.interior || b_cls_q.border);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      credit_q  <= '0;
    end else begin
      a_valid_q <= pop;
      b_valid_q <= a_valid_q;
      credit_q  <= credit_d;
    end
  end

endmodule

@@ hdl/gmf_emit.sv @@
module gmf_emit import gmf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  res_t               res_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [PIX_W-1:0]   value_o,
  output logic [COORD_W-1:0] row_o,
  output logic [COORD_W-1:0] col_o,
  output logic               last_o,
  output logic               retire_o
);

  logic second_q;
  logic send_int;
  logic beat;

  // interior beat goes first; hold the entry until its last beat
  assign send_int    = res_i.has_int && !second_q;
  assign out_valid_o = res_valid_i;
  assign value_o     = send_int ? res_i.int_val : res_i.bor_val;
  assign row_o       = send_int ? res_i.int_row : res_i.bor_row;
  assign col_o       = send_int ? res_i.int_col : res_i.bor_col;
  assign last_o      = !(send_int && res_i.has_bor);
  assign beat        = out_valid_o && out_ready_i;
  assign retire_o    = beat && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (beat) begin
      second_q <= !last_o;
    end
  end

endmodule

@@ hdl/grayscale_morphology_filter.sv @@
// Channel   Direction  Handshake                Payload
// pixel     in         in_valid_i / in_ready_o  pixel_i
// result    out        out_valid_o / out_ready_i value_o, row_o, col_o, last_o
// config    in         cfg_we_i (no wait)       cfg_idx_i, cfg_data_i
//
// Takes one pixel per cycle; a pixel that yields an interior and a border result
// needs two output beats, and the single result port sets that rate.
// On its way out a result passes the classify queue, the line store read, two compare
// stages and the result queue. Reset clears counters and queues; line stores and the
// window are not cleared and need no sweep. Output stalls fill the result queue,
// then the classify queue, then drop in_ready_o.
`include "assert_macros.svh"

module grayscale_morphology_filter import gmf_pkg::*; #(
  parameter int unsigned KERNEL_SIZE = 3,
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      value_o,
  output logic [COORD_W-1:0]    row_o,
  output logic [COORD_W-1:0]    col_o,
  output logic                  last_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = $clog2(KERNEL_SIZE - 1);
  localparam int unsigned QW = $bits(cls_t) + CW + PW;
  localparam int unsigned RSW = $bits(res_t);

  cfg_t          cfg_q;

  logic          cq_push, cq_pop, cq_empty, cq_full;
  cls_t          f_cls, b_cls;
  logic [CW-1:0] f_addr, b_addr;
  logic [PW-1:0] f_slot, b_slot;
  logic [QW-1:0] cq_wdata, cq_rdata;

  logic           res_push, res_empty, res_full, retire;
  res_t           res_in, res_head;
  logic [RSW-1:0] res_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_ERODE;
      cfg_q.mask   <= MASK_RST;
      cfg_q.width  <= DIM_RST;
      cfg_q.height <= DIM_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODE:   cfg_q.mode   <= mode_e'(cfg_data_i[0]);
        REG_MASK:   cfg_q.mask   <= cfg_data_i[MASK_W-1:0];
        REG_WIDTH:  cfg_q.width  <= cfg_data_i;
        REG_HEIGHT: cfg_q.height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gmf_front #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .pixel_i    (pixel_i),
    .q_full_i   (cq_full),
    .in_ready_o (in_ready_o),
    .push_o     (cq_push),
    .cls_o      (f_cls),
    .addr_o     (f_addr),
    .slot_o     (f_slot)
  );

  assign cq_wdata = {f_slot, f_addr, f_cls};
  assign {b_slot, b_addr, b_cls} = cq_rdata;

  gmf_fifo #(
    .WIDTH (QW),
    .DEPTH (CLS_DEPTH)
  ) u_cls_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cq_wdata),
    .pop_i   (cq_pop),
    .data_o  (cq_rdata),
    .empty_o (cq_empty),
    .full_o  (cq_full)
  );

  gmf_back #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (!cq_empty),
    .q_cls_i    (b_cls),
    .q_addr_i   (b_addr),
    .q_slot_i   (b_slot),
    .q_pop_o    (cq_pop),
    .retire_i   (retire),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  gmf_fifo #(
    .WIDTH (RSW),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (retire),
    .data_o  (res_rdata),
    .empty_o (res_empty),
    .full_o  (res_full)
  );

  assign res_head = res_t'(res_rdata);

  gmf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (!res_empty),
    .res_i       (res_head),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .value_o     (value_o),
    .row_o       (row_o),
    .col_o       (col_o),
    .last_o      (last_o),
    .retire_o    (retire)
  );

  // credit scheme must keep the result queue from overflowing
  `GMF_ASSERT_NEVER(a_res_overflow, res_push && res_full)
  // after the interior beat of a pair the border beat follows and closes it
  `GMF_ASSERT(a_pair_follows, out_valid_o && out_ready_i && !last_o |=> out_valid_o && last_o)
  `GMF_ASSERT(a_pair_source, out_valid_o && !last_o |-> res_head.has_int && res_head.has_bor)

endmodule

@@ dv/grayscale_morphology_filter_tb.sv @@
`timescale 1ns / 100ps

module grayscale_morphology_filter_tb import gmf_pkg::*; ();

  localparam int unsigned K             = 3;
  localparam int unsigned HALF          = K / 2;
  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned MAX_H         = 1024;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PRINT_LIMIT   = 100;

  typedef enum logic [2:0] {
    CMD_PIXEL,
    CMD_WRITE,
    CMD_SETTLE,
    CMD_PACE,
    CMD_HOLD
  } cmd_kind_e;

  // v carries the pixel, the register data or the sender idle rate
  typedef struct {
    cmd_kind_e   kind;
    int unsigned v;
    reg_idx_e    idx;
    int unsigned b;
  } feed_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } pix_result_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      pixel_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      value_o;
  logic [COORD_W-1:0]    row_o;
  logic [COORD_W-1:0]    col_o;
  logic                  last_o;

  feed_cmd_t   feed_q [$];
  pix_result_t filtered_q [$];
  int unsigned outstanding   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;
  int unsigned mismatches    = 0;

  // filter state mirrored from the block
  logic [PIX_W-1:0]  line_mem [K-1][MAX_W];
  logic [PIX_W-1:0]  win [K][K];
  int unsigned       row_pos;
  int unsigned       col_pos;
  mode_e             cur_mode;
  logic [MASK_W-1:0] cur_mask;
  logic [DIM_W-1:0]  cur_width;
  logic [DIM_W-1:0]  cur_height;

  grayscale_morphology_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .row_o      (row_o),
    .col_o      (col_o),
    .last_o     (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < K) return K;
    if (v > hi) return hi;
    return v;
  endfunction

  // Work out the results that one accepted pixel causes and queue them.
  function automatic void filter_pixel(logic [PIX_W-1:0] pix);
    int unsigned w, h, r, c, ci;
    logic [PIX_W-1:0] acc;
    pix_result_t one;
    pix_result_t res [$];
    w  = fit_dim(cur_width, MAX_W);
    h  = fit_dim(cur_height, MAX_H);
    r  = row_pos;
    c  = col_pos;
    ci = (c < MAX_W) ? c : MAX_W - 1;
    for (int i = 0; i < K; i++)
      for (int j = 0; j + 1 < K; j++)
        win[i][j] = win[i][j+1];
    for (int i = 0; i < K - 1; i++)
      win[i][K-1] = line_mem[(r + i) % (K - 1)][ci];
    win[K-1][K-1] = pix;
    line_mem[r % (K - 1)][ci] = pix;

    if (r >= K - 1 && c >= K - 1 && r + 2 * HALF <= h + K - 2 &&
        c + 2 * HALF <= w + K - 2) begin
      acc = (cur_mode == MODE_DILATE) ? '0 : '1;
      for (int i = 0; i < K; i++)
        for (int j = 0; j < K; j++)
          if (i * K + j < MASK_W && cur_mask[i*K+j]) begin
            if (cur_mode == MODE_DILATE) begin
              if (win[i][j] > acc) acc = win[i][j];
            end else if (win[i][j] < acc) begin
              acc = win[i][j];
            end
          end
      one = '{value: acc, row: COORD_W'(r - (K - 1) + HALF),
              col: COORD_W'(c - (K - 1) + HALF), last: 1'b0};
      res.insert(res.size(), one);
    end
    if (r < HALF || r + HALF >= h || c < HALF || c + HALF >= w) begin
      one = '{value: pix, row: COORD_W'(r), col: COORD_W'(c), last: 1'b0};
      res.insert(res.size(), one);
    end
    if (res.size() != 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) filtered_q.insert(filtered_q.size(), res[i]);

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void feed(cmd_kind_e kind, int unsigned v = 0,
                               reg_idx_e idx = REG_MODE, int unsigned b = 0);
    feed_cmd_t cmd;
    cmd = '{kind: kind, v: v, idx: idx, b: b};
    feed_q.insert(feed_q.size(), cmd);
  endfunction

  function automatic int unsigned pick_pixel();
    case ($urandom_range(9))
      0: return 0;
      1: return 16'hFFFF;
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // Queue one frame with fresh settings; returns the number of pixels queued.
  function automatic int unsigned feed_frame();
    int unsigned w, h, r0, c0, total, pause;
    feed(CMD_WRITE, $urandom_range(1), REG_MODE);
    feed(CMD_WRITE, pick_mask(), REG_MASK);
    w = ($urandom_range(15) == 0) ? $urandom_range(48, 13) : $urandom_range(12, K);
    h = $urandom_range(8, K);
    // an undersized size write clamps to the kernel size
    if ($urandom_range(9) == 0) begin
      w = K;
      feed(CMD_WRITE, $urandom_range(K - 1), REG_WIDTH);
    end else begin
      feed(CMD_WRITE, w, REG_WIDTH);
    end
    if ($urandom_range(9) == 0) begin
      h = K;
      feed(CMD_WRITE, $urandom_range(K - 1), REG_HEIGHT);
    end else begin
      feed(CMD_WRITE, h, REG_HEIGHT);
    end

    if (h > K && $urandom_range(3) == 0) begin
      // cut the frame: shrink it below the current position so the counters wrap
      r0 = $urandom_range(h - 1, K);
      c0 = $urandom_range(w - 1);
      repeat (r0 * w + c0) feed(CMD_PIXEL, pick_pixel());
      feed(CMD_WRITE, $urandom_range(r0, K), REG_HEIGHT);
      if (c0 >= K) begin
        feed(CMD_WRITE, $urandom_range(c0, K), REG_WIDTH);
        total = 1;
      end else begin
        total = w - c0;
      end
      repeat (total) feed(CMD_PIXEL, pick_pixel());
      return r0 * w + c0 + total;
    end

    total = w * h;
    pause = ($urandom_range(2) == 0) ? $urandom_range(total - 1, 1) : 0;
    for (int i = 0; i < total; i++) begin
      if (i == pause && i != 0) begin
        feed(CMD_SETTLE);
        if ($urandom_range(1) == 0) begin
          feed(CMD_WRITE, $urandom_range(1), REG_MODE);
          feed(CMD_WRITE, pick_mask(), REG_MASK);
        end
      end
      feed(CMD_PIXEL, pick_pixel());
    end
    return total;
  endfunction

  // Sender and configuration writer.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    feed_cmd_t             head;
    logic                  took, nv, nwe, nhold;
    logic [PIX_W-1:0]      npix;
    logic [CFG_IDX_W-1:0]  nidx;
    logic [CFG_DATA_W-1:0] ndata;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      pixel_i      <= '0;
      cfg_we_i     <= 1'b0;
      cfg_idx_i    <= '0;
      cfg_data_i   <= '0;
      hold_req     <= 1'b0;
      quiet_cycles = 0;
    end else begin
      took  = in_valid_i && in_ready_o;
      nv    = in_valid_i && !took;
      npix  = pixel_i;
      nwe   = 1'b0;
      nhold = 1'b0;
      nidx  = cfg_idx_i;
      ndata = cfg_data_i;
      if (in_valid_i || outstanding != 0) quiet_cycles = 0;
      else quiet_cycles++;

      if (!nv && feed_q.size() != 0) begin
        head = feed_q[0];
        case (head.kind)
          CMD_PIXEL: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              nv   = 1'b1;
              npix = head.v[PIX_W-1:0];
              feed_q.delete(0);
            end
          end
          CMD_WRITE: begin
            // write only once the block has drained
            if (quiet_cycles >= SETTLE_CYCLES) begin
              nwe   = 1'b1;
              nidx  = head.idx;
              ndata = head.v[CFG_DATA_W-1:0];
              feed_q.delete(0);
            end
          end
          CMD_SETTLE: begin
            if (quiet_cycles >= SETTLE_CYCLES) feed_q.delete(0);
          end
          CMD_PACE: begin
            send_idle_pct = head.v;
            recv_idle_pct <= head.b;
            feed_q.delete(0);
          end
          CMD_HOLD: begin
            nhold = 1'b1;
            feed_q.delete(0);
          end
          default: feed_q.delete(0);
        endcase
      end

      in_valid_i <= nv;
      pixel_i    <= npix;
      cfg_we_i   <= nwe;
      cfg_idx_i  <= nidx;
      cfg_data_i <= ndata;
      hold_req   <= nhold;
    end
  end

  // Receiver: random back-pressure, or a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_req) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check result beats, track register writes, predict from pixel beats.
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    pix_result_t want;
    if (!rst_ni) begin
      filtered_q.delete();
      row_pos     = 0;
      col_pos     = 0;
      cur_mode    = MODE_ERODE;
      cur_mask    = MASK_RST;
      cur_width   = DIM_RST;
      cur_height  = DIM_RST;
      outstanding <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat value %h at (%0d,%0d) last %b",
                                  value_o, row_o, col_o, last_o));
        end else begin
          want = filtered_q.pop_front();
          if (value_o !== want.value)
            flag_mismatch($sformatf("value at (%0d,%0d): got %h, want %h",
                                    want.row, want.col, value_o, want.value));
          if (row_o !== want.row)
            flag_mismatch($sformatf("row: got %0d, want %0d", row_o, want.row));
          if (col_o !== want.col)
            flag_mismatch($sformatf("col: got %0d, want %0d", col_o, want.col));
          if (last_o !== want.last)
            flag_mismatch($sformatf("last at (%0d,%0d): got %b, want %b",
                                    want.row, want.col, last_o, want.last));
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_MODE:   cur_mode   = mode_e'(cfg_data_i[0]);
          REG_MASK:   cur_mask   = cfg_data_i[MASK_W-1:0];
          REG_WIDTH:  cur_width  = cfg_data_i[DIM_W-1:0];
          REG_HEIGHT: cur_height = cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) filter_pixel(pixel_i);
      outstanding <= filtered_q.size();
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned fed;
    feed(CMD_PACE, 13, REG_MODE, 46);

    // 3x3 frame at the reset mode and mask: erosion with the cross
    feed(CMD_WRITE, K, REG_WIDTH);
    feed(CMD_WRITE, K, REG_HEIGHT);
    feed(CMD_PIXEL, 16'h0000); feed(CMD_PIXEL, 16'hFFFF); feed(CMD_PIXEL, 16'h8000);
    feed(CMD_PIXEL, 16'h0001); feed(CMD_PIXEL, 16'h7FFF); feed(CMD_PIXEL, 16'h5555);
    feed(CMD_PIXEL, 16'hAAAA); feed(CMD_PIXEL, 16'h1234); feed(CMD_PIXEL, 16'hFEDC);

    // dilation with an empty mask, sizes below the kernel clamp up
    feed(CMD_WRITE, MODE_DILATE, REG_MODE);
    feed(CMD_WRITE, 0, REG_MASK);
    feed(CMD_WRITE, 0, REG_WIDTH);
    feed(CMD_WRITE, 2, REG_HEIGHT);
    repeat (9) feed(CMD_PIXEL, 16'hFFFF);

    // erosion with an empty mask; then shrink the frame under the counters
    feed(CMD_WRITE, MODE_ERODE, REG_MODE);
    feed(CMD_WRITE, 0, REG_MASK);
    feed(CMD_WRITE, 4, REG_WIDTH);
    feed(CMD_WRITE, 5, REG_HEIGHT);
    repeat (8) feed(CMD_PIXEL, 16'h0000);
    feed(CMD_SETTLE);
    repeat (7) feed(CMD_PIXEL, 16'h0000);
    feed(CMD_WRITE, K, REG_WIDTH);
    feed(CMD_WRITE, K, REG_HEIGHT);
    feed(CMD_PIXEL, 16'h0F0F);

    fed = 0;
    while (fed < 110) fed += feed_frame();

    feed(CMD_PACE, 46, REG_MODE, 13);
    fed = 0;
    while (fed < 110) fed += feed_frame();

    feed(CMD_PACE, 0, REG_MODE, 0);
    fed = 0;
    while (fed < 110) fed += feed_frame();

    // oversized writes clamp down; cut each frame short and stall the output meanwhile
    feed(CMD_WRITE, 2047, REG_WIDTH);
    feed(CMD_WRITE, 2047, REG_HEIGHT);
    feed(CMD_HOLD);
    repeat (40) feed(CMD_PIXEL, pick_pixel());
    feed(CMD_WRITE, K, REG_WIDTH);
    feed(CMD_WRITE, K, REG_HEIGHT);
    repeat (2 * K + 1) feed(CMD_PIXEL, pick_pixel());
    feed(CMD_WRITE, $urandom_range(1), REG_MODE);
    feed(CMD_WRITE, pick_mask(), REG_MASK);
    feed(CMD_WRITE, 2047, REG_HEIGHT);
    feed(CMD_HOLD);
    repeat (15 * K) feed(CMD_PIXEL, pick_pixel());
    feed(CMD_WRITE, K, REG_HEIGHT);
    repeat (K) feed(CMD_PIXEL, pick_pixel());
    feed(CMD_SETTLE);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (feed_q.size() != 0 || in_valid_i);

    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
